FILE: hw/rtl/fpk_pkg.sv
// Shared types, constants and helper functions of the free rectangle packer.
`timescale 1ns / 1ps
`default_nettype none
package fpk_pkg;

   localparam int MAX_FREE   = 64;
   localparam int FA_BITS    = $clog2(MAX_FREE);
   localparam int FC_BITS    = FA_BITS + 1;
   localparam int MAX_PIECE  = 4 * MAX_FREE;
   localparam int PA_BITS    = $clog2(MAX_PIECE);
   localparam int PC_BITS    = PA_BITS + 1;
   localparam int COORD_BITS = 12;
   localparam int CRD_BITS   = 16;
   localparam int SQ_BITS    = 32;
   localparam int MIN_W      = 1;
   localparam int MIN_H      = 1;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_OCCUPY = 2'd2;
   localparam logic [1:0] CMD_FORBID = 2'd3;

   localparam logic [2:0] REG_REGION_X = 3'd0;
   localparam logic [2:0] REG_REGION_Y = 3'd1;
   localparam logic [2:0] REG_REGION_W = 3'd2;
   localparam logic [2:0] REG_REGION_H = 3'd3;
   localparam logic [2:0] REG_PAD_L    = 3'd4;
   localparam logic [2:0] REG_PAD_R    = 3'd5;
   localparam logic [2:0] REG_PAD_T    = 3'd6;
   localparam logic [2:0] REG_PAD_B    = 3'd7;

   typedef logic signed [CRD_BITS-1:0] crd_type;

   typedef struct packed {
      crd_type x;
      crd_type y;
      crd_type w;
      crd_type h;
   } box_type;

   typedef struct packed {
      logic [10:0] region_x;
      logic [10:0] region_y;
      logic [10:0] region_w;
      logic [10:0] region_h;
      logic [7:0]  pad_left;
      logic [7:0]  pad_right;
      logic [7:0]  pad_top;
      logic [7:0]  pad_bottom;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_CLEAR, OP_PAD, OP_CLAMP, OP_SINIT, OP_FRD, OP_FEVAL,
      OP_FMUL, OP_FSKIP, OP_FCMP, OP_FHIT, OP_FAIL, OP_APPLY, OP_OPSET, OP_OINIT,
      OP_ORD, OP_OEVAL, OP_PIECE, OP_CNTSET, OP_ARD, OP_AEVAL, OP_BRD, OP_BEVAL,
      OP_NEXTI, OP_AINIT, OP_CRD, OP_CWR, OP_RESP
   } op_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       scan_done;
      logic       hit;
      logic       fit;
      logic       found;
      logic       ov_split;
      logic       piece_last;
      logic       fi_done;
      logic       fj_done;
      logic       a_small;
      logic       b_gone;
   } sts_type;

   function automatic crd_type u11(input logic [10:0] v);
      return crd_type'({{(CRD_BITS-11){1'b0}}, v});
   endfunction

   function automatic crd_type u8(input logic [7:0] v);
      return crd_type'({{(CRD_BITS-8){1'b0}}, v});
   endfunction

   function automatic crd_type s12(input logic [11:0] v);
      return crd_type'({{(CRD_BITS-12){v[11]}}, v});
   endfunction

   function automatic logic inside_f(input box_type a, input box_type b);
      return (a.x >= b.x) && (a.y >= b.y) &&
             (a.x + a.w <= b.x + b.w) && (a.y + a.h <= b.y + b.h);
   endfunction

   function automatic logic overlap_f(input box_type a, input box_type b);
      return (a.x < b.x + b.w) && (b.x < a.x + a.w) &&
             (a.y < b.y + b.h) && (b.y < a.y + a.h);
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fpk_csr.sv
// Configuration registers of the free rectangle packer.
`timescale 1ns / 1ps
`default_nettype none
module fpk_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [10:0]      csr_wdata,
   output fpk_pkg::cfg_type      cfg
);
   import fpk_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_REGION_X: cfg_in.region_x   = csr_wdata;
            REG_REGION_Y: cfg_in.region_y   = csr_wdata;
            REG_REGION_W: cfg_in.region_w   = csr_wdata;
            REG_REGION_H: cfg_in.region_h   = csr_wdata;
            REG_PAD_L:    cfg_in.pad_left   = csr_wdata[7:0];
            REG_PAD_R:    cfg_in.pad_right  = csr_wdata[7:0];
            REG_PAD_T:    cfg_in.pad_top    = csr_wdata[7:0];
            REG_PAD_B:    cfg_in.pad_bottom = csr_wdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.region_x   <= 11'd0;
         cfg_ff.region_y   <= 11'd0;
         cfg_ff.region_w   <= 11'd256;
         cfg_ff.region_h   <= 11'd256;
         cfg_ff.pad_left   <= 8'd0;
         cfg_ff.pad_right  <= 8'd0;
         cfg_ff.pad_top    <= 8'd0;
         cfg_ff.pad_bottom <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/fpk_ctrl.sv
// Sequencing state machine of the free rectangle packer.
`timescale 1ns / 1ps
`default_nettype none
module fpk_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire fpk_pkg::sts_type sts,
   output fpk_pkg::ctl_type      ctl
);
   import fpk_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DISP  = 5'd1;
   localparam logic [4:0] S_CLAMP = 5'd2;
   localparam logic [4:0] S_SINIT = 5'd3;
   localparam logic [4:0] S_FRD   = 5'd4;
   localparam logic [4:0] S_FEVAL = 5'd5;
   localparam logic [4:0] S_FMUL  = 5'd6;
   localparam logic [4:0] S_FCMP  = 5'd7;
   localparam logic [4:0] S_FEND  = 5'd8;
   localparam logic [4:0] S_OINIT = 5'd9;
   localparam logic [4:0] S_ORD   = 5'd10;
   localparam logic [4:0] S_OEVAL = 5'd11;
   localparam logic [4:0] S_PIECE = 5'd12;
   localparam logic [4:0] S_ARD   = 5'd13;
   localparam logic [4:0] S_AEVAL = 5'd14;
   localparam logic [4:0] S_BRD   = 5'd15;
   localparam logic [4:0] S_BEVAL = 5'd16;
   localparam logic [4:0] S_CRD   = 5'd17;
   localparam logic [4:0] S_CWR   = 5'd18;
   localparam logic [4:0] S_RESP  = 5'd19;

   logic [4:0] state_ff, state_in;
   op_type     op;

   assign busy   = (state_ff != S_IDLE);
   assign ctl.op = op;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op       = OP_LATCH;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (sts.cmd)
               CMD_CLEAR: begin
                  op       = OP_CLEAR;
                  state_in = S_RESP;
               end
               CMD_FORBID: begin
                  op       = OP_OPSET;
                  state_in = S_OINIT;
               end
               default: begin
                  op       = OP_PAD;
                  state_in = S_CLAMP;
               end
            endcase
         end
         S_CLAMP: begin
            op       = OP_CLAMP;
            state_in = S_SINIT;
         end
         S_SINIT: begin
            op       = OP_SINIT;
            state_in = S_FRD;
         end
         S_FRD: begin
            if (sts.scan_done) begin
               state_in = S_FEND;
            end else begin
               op       = OP_FRD;
               state_in = S_FEVAL;
            end
         end
         S_FEVAL: begin
            op       = OP_FEVAL;
            state_in = S_FMUL;
         end
         S_FMUL: begin
            priority if (sts.hit) begin
               op       = OP_FHIT;
               state_in = S_FEND;
            end else if (!sts.fit) begin
               op       = OP_FSKIP;
               state_in = S_FRD;
            end else begin
               op       = OP_FMUL;
               state_in = S_FCMP;
            end
         end
         S_FCMP: begin
            op       = OP_FCMP;
            state_in = S_FRD;
         end
         S_FEND: begin
            if (!sts.found) begin
               op       = OP_FAIL;
               state_in = S_RESP;
            end else begin
               op       = OP_APPLY;
               state_in = (sts.cmd == CMD_OCCUPY) ? S_OINIT : S_RESP;
            end
         end
         S_OINIT: begin
            op       = OP_OINIT;
            state_in = S_ORD;
         end
         S_ORD: begin
            if (sts.scan_done) begin
               op       = OP_CNTSET;
               state_in = S_ARD;
            end else begin
               op       = OP_ORD;
               state_in = S_OEVAL;
            end
         end
         S_OEVAL: begin
            op       = OP_OEVAL;
            state_in = sts.ov_split ? S_PIECE : S_ORD;
         end
         S_PIECE: begin
            op       = OP_PIECE;
            state_in = sts.piece_last ? S_ORD : S_PIECE;
         end
         S_ARD: begin
            if (sts.fi_done) begin
               op       = OP_AINIT;
               state_in = S_CRD;
            end else begin
               op       = OP_ARD;
               state_in = S_AEVAL;
            end
         end
         S_AEVAL: begin
            op       = OP_AEVAL;
            state_in = sts.a_small ? S_ARD : S_BRD;
         end
         S_BRD: begin
            if (sts.fj_done) begin
               op       = OP_NEXTI;
               state_in = S_ARD;
            end else begin
               op       = OP_BRD;
               state_in = S_BEVAL;
            end
         end
         S_BEVAL: begin
            op       = OP_BEVAL;
            state_in = sts.b_gone ? S_ARD : S_BRD;
         end
         S_CRD: begin
            if (sts.fi_done) begin
               state_in = S_RESP;
            end else begin
               op       = OP_CRD;
               state_in = S_CWR;
            end
         end
         S_CWR: begin
            op       = OP_CWR;
            state_in = S_CRD;
         end
         S_RESP: begin
            op       = OP_RESP;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/fpk_dp.sv
// Datapath of the free rectangle packer: free list, piece buffer and arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module fpk_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fpk_pkg::ctl_type     ctl,
   output fpk_pkg::sts_type          sts,
   input  wire fpk_pkg::cfg_type     cfg,
   input  wire logic [1:0]           req_cmd,
   input  wire logic signed [11:0]   req_rect_x,
   input  wire logic signed [11:0]   req_rect_y,
   input  wire logic [10:0]          req_rect_w,
   input  wire logic [10:0]          req_rect_h,
   output logic                      rsp_valid,
   output logic                      rsp_status,
   output logic signed [11:0]        rsp_place_x,
   output logic signed [11:0]        rsp_place_y,
   output logic                      rsp_list_overflow
);
   import fpk_pkg::*;

   box_type free_mem [MAX_FREE];
   box_type piece_mem [MAX_PIECE];
   logic    drop_mem [MAX_PIECE];

   logic               f_we;
   logic [FA_BITS-1:0] f_waddr;
   box_type            f_wdata;
   box_type            f_rdata_ff;
   logic               p_we;
   logic [PA_BITS-1:0] p_waddr;
   box_type            p_wdata;
   logic [PA_BITS-1:0] p_raddr;
   box_type            p_rdata_ff;
   logic               d_we;
   logic [PA_BITS-1:0] d_waddr;
   logic               d_wdata;
   logic               d_rdata_ff;

   logic [1:0]           cmd_ff, cmd_in;
   box_type              req_ff, req_in;
   box_type              t_ff, t_in;
   box_type              p_ff, p_in;
   box_type              r_ff, r_in;
   box_type              a_ff, a_in;
   logic [FC_BITS-1:0]   cnt_ff, cnt_in;
   logic [FC_BITS-1:0]   idx_ff, idx_in;
   logic [FC_BITS-1:0]   keep_ff, keep_in;
   logic [PC_BITS-1:0]   n_ff, n_in;
   logic [PC_BITS-1:0]   fi_ff, fi_in;
   logic [PC_BITS-1:0]   fj_ff, fj_in;
   logic [1:0]           k_ff, k_in;
   logic                 found_ff, found_in;
   logic                 hit_ff, hit_in;
   logic                 fit_ff, fit_in;
   crd_type              cdx_ff, cdx_in, cdy_ff, cdy_in;
   crd_type              bdx_ff, bdx_in, bdy_ff, bdy_in;
   logic signed [SQ_BITS-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in, best_ff, best_in, dsum;
   logic                 fail_ff, fail_in;
   logic [COORD_BITS-1:0] resx_ff, resx_in, resy_ff, resy_in;
   logic                 ovf_ff, ovf_in;
   logic                 rv_ff, rv_in;

   box_type region;
   crd_type rx_end, ry_end, new_x, new_y;
   logic    pc_cond;
   box_type pc_box;
   logic    b_eq;

   assign region = '{x: u11(cfg.region_x), y: u11(cfg.region_y),
                     w: u11(cfg.region_w), h: u11(cfg.region_h)};
   assign rx_end = region.x + region.w;
   assign ry_end = region.y + region.h;
   assign dsum   = sqx_ff + sqy_ff;
   assign new_x  = t_ff.x + bdx_ff + u8(cfg.pad_left);
   assign new_y  = t_ff.y + bdy_ff + u8(cfg.pad_top);
   assign b_eq   = (a_ff == p_rdata_ff);
   assign p_raddr = (ctl.op == OP_BRD) ? fj_ff[PA_BITS-1:0] : fi_ff[PA_BITS-1:0];

   always_comb begin
      pc_cond = 1'b0;
      pc_box  = r_ff;
      unique case (k_ff)
         2'd0: begin
            pc_cond  = (p_ff.x + p_ff.w < r_ff.x + r_ff.w);
            pc_box.x = p_ff.x + p_ff.w;
            pc_box.w = r_ff.x + r_ff.w - p_ff.x - p_ff.w;
         end
         2'd1: begin
            pc_cond  = (p_ff.y + p_ff.h < r_ff.y + r_ff.h);
            pc_box.y = p_ff.y + p_ff.h;
            pc_box.h = r_ff.y + r_ff.h - p_ff.y - p_ff.h;
         end
         2'd2: begin
            pc_cond  = (p_ff.x > r_ff.x);
            pc_box.w = p_ff.x - r_ff.x;
         end
         default: begin
            pc_cond  = (p_ff.y > r_ff.y);
            pc_box.h = p_ff.y - r_ff.y;
         end
      endcase
   end

   always_comb begin
      sts.cmd        = cmd_ff;
      sts.scan_done  = (idx_ff == cnt_ff);
      sts.hit        = hit_ff;
      sts.fit        = fit_ff;
      sts.found      = found_ff;
      sts.ov_split   = overlap_f(f_rdata_ff, p_ff) && !inside_f(f_rdata_ff, p_ff);
      sts.piece_last = (k_ff == 2'd3);
      sts.fi_done    = (fi_ff == n_ff);
      sts.fj_done    = (fj_ff == n_ff);
      sts.a_small    = (p_rdata_ff.w < crd_type'(MIN_W)) || (p_rdata_ff.h < crd_type'(MIN_H));
      sts.b_gone     = (fj_ff != fi_ff) && !d_rdata_ff &&
                       ((b_eq && (fi_ff < fj_ff)) || (!b_eq && inside_f(a_ff, p_rdata_ff)));
   end

   always_comb begin
      cmd_in = cmd_ff;  req_in = req_ff;  t_in = t_ff;  p_in = p_ff;
      r_in = r_ff;  a_in = a_ff;  cnt_in = cnt_ff;  idx_in = idx_ff;
      keep_in = keep_ff;  n_in = n_ff;  fi_in = fi_ff;  fj_in = fj_ff;
      k_in = k_ff;  found_in = found_ff;  hit_in = hit_ff;
      fit_in = fit_ff;  cdx_in = cdx_ff;  cdy_in = cdy_ff;  bdx_in = bdx_ff;
      bdy_in = bdy_ff;  sqx_in = sqx_ff;  sqy_in = sqy_ff;  best_in = best_ff;
      fail_in = fail_ff;  resx_in = resx_ff;  resy_in = resy_ff;  ovf_in = ovf_ff;
      rv_in = 1'b0;
      f_we = 1'b0;  f_waddr = keep_ff[FA_BITS-1:0];  f_wdata = f_rdata_ff;
      p_we = 1'b0;  p_waddr = n_ff[PA_BITS-1:0];  p_wdata = pc_box;
      d_we = 1'b0;  d_waddr = fi_ff[PA_BITS-1:0];  d_wdata = 1'b1;
      unique case (ctl.op)
         OP_LATCH: begin
            cmd_in  = req_cmd;
            req_in  = '{x: s12(req_rect_x), y: s12(req_rect_y),
                        w: u11(req_rect_w), h: u11(req_rect_h)};
            fail_in = 1'b0;
            resx_in = '0;
            resy_in = '0;
            ovf_in  = 1'b0;
         end
         OP_CLEAR: begin
            f_we    = 1'b1;
            f_waddr = '0;
            f_wdata = region;
            cnt_in  = FC_BITS'(1);
         end
         OP_PAD: begin
            t_in.x = req_ff.x - u8(cfg.pad_left);
            t_in.y = req_ff.y - u8(cfg.pad_top);
            t_in.w = req_ff.w + u8(cfg.pad_left) + u8(cfg.pad_right);
            t_in.h = req_ff.h + u8(cfg.pad_top) + u8(cfg.pad_bottom);
         end
         OP_CLAMP: begin
            priority if (t_ff.x < region.x) t_in.x = region.x;
            else if (t_ff.x + t_ff.w > rx_end) t_in.x = rx_end - t_ff.w;
            else t_in.x = t_ff.x;
            priority if (t_ff.y < region.y) t_in.y = region.y;
            else if (t_ff.y + t_ff.h > ry_end) t_in.y = ry_end - t_ff.h;
            else t_in.y = t_ff.y;
         end
         OP_SINIT: begin
            idx_in   = '0;
            found_in = 1'b0;
            bdx_in   = '0;
            bdy_in   = '0;
            best_in  = '0;
         end
         OP_FEVAL: begin
            hit_in = inside_f(t_ff, f_rdata_ff);
            fit_in = (t_ff.w <= f_rdata_ff.w) && (t_ff.h <= f_rdata_ff.h);
            priority if (t_ff.x < f_rdata_ff.x) cdx_in = f_rdata_ff.x - t_ff.x;
            else if (t_ff.x + t_ff.w > f_rdata_ff.x + f_rdata_ff.w)
               cdx_in = f_rdata_ff.x + f_rdata_ff.w - t_ff.x - t_ff.w;
            else cdx_in = '0;
            priority if (t_ff.y < f_rdata_ff.y) cdy_in = f_rdata_ff.y - t_ff.y;
            else if (t_ff.y + t_ff.h > f_rdata_ff.y + f_rdata_ff.h)
               cdy_in = f_rdata_ff.y + f_rdata_ff.h - t_ff.y - t_ff.h;
            else cdy_in = '0;
         end
         OP_FMUL: begin
            sqx_in = cdx_ff * cdx_ff;
            sqy_in = cdy_ff * cdy_ff;
         end
         OP_FSKIP: idx_in = idx_ff + FC_BITS'(1);
         OP_FCMP: begin
            if (!found_ff || (dsum < best_ff)) begin
               found_in = 1'b1;
               best_in  = dsum;
               bdx_in   = cdx_ff;
               bdy_in   = cdy_ff;
            end
            idx_in = idx_ff + FC_BITS'(1);
         end
         OP_FHIT: begin
            found_in = 1'b1;
            bdx_in   = '0;
            bdy_in   = '0;
         end
         OP_FAIL: fail_in = 1'b1;
         OP_APPLY: begin
            p_in    = '{x: new_x, y: new_y, w: req_ff.w, h: req_ff.h};
            resx_in = new_x[COORD_BITS-1:0];
            resy_in = new_y[COORD_BITS-1:0];
         end
         OP_OPSET: p_in = req_ff;
         OP_OINIT: begin
            idx_in  = '0;
            keep_in = '0;
            n_in    = '0;
         end
         OP_OEVAL: begin
            priority if (!overlap_f(f_rdata_ff, p_ff)) begin
               f_we    = 1'b1;
               keep_in = keep_ff + FC_BITS'(1);
               idx_in  = idx_ff + FC_BITS'(1);
            end else if (inside_f(f_rdata_ff, p_ff)) begin
               idx_in = idx_ff + FC_BITS'(1);
            end else begin
               r_in = f_rdata_ff;
               k_in = 2'd0;
            end
         end
         OP_PIECE: begin
            if (pc_cond) begin
               p_we    = 1'b1;
               d_we    = 1'b1;
               d_waddr = n_ff[PA_BITS-1:0];
               d_wdata = 1'b0;
               n_in    = n_ff + PC_BITS'(1);
            end
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) idx_in = idx_ff + FC_BITS'(1);
         end
         OP_CNTSET: begin
            cnt_in = keep_ff;
            fi_in  = '0;
         end
         OP_AEVAL: begin
            a_in  = p_rdata_ff;
            fj_in = '0;
            if (sts.a_small) begin
               d_we  = 1'b1;
               fi_in = fi_ff + PC_BITS'(1);
            end
         end
         OP_BEVAL: begin
            if (sts.b_gone) begin
               d_we  = 1'b1;
               fi_in = fi_ff + PC_BITS'(1);
            end else begin
               fj_in = fj_ff + PC_BITS'(1);
            end
         end
         OP_NEXTI: fi_in = fi_ff + PC_BITS'(1);
         OP_AINIT: fi_in = '0;
         OP_CWR: begin
            if (!d_rdata_ff) begin
               if (cnt_ff < FC_BITS'(MAX_FREE)) begin
                  f_we    = 1'b1;
                  f_waddr = cnt_ff[FA_BITS-1:0];
                  f_wdata = p_rdata_ff;
                  cnt_in  = cnt_ff + FC_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            fi_in = fi_ff + PC_BITS'(1);
         end
         OP_RESP: rv_in = 1'b1;
         default: rv_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (f_we) free_mem[f_waddr] <= f_wdata;
      f_rdata_ff <= free_mem[idx_ff[FA_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (p_we) piece_mem[p_waddr] <= p_wdata;
      p_rdata_ff <= piece_mem[p_raddr];
   end

   always_ff @(posedge clock) begin
      if (d_we) drop_mem[d_waddr] <= d_wdata;
      d_rdata_ff <= drop_mem[p_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rv_ff  <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  req_ff <= req_in;  t_ff <= t_in;  p_ff <= p_in;
      r_ff <= r_in;  a_ff <= a_in;  idx_ff <= idx_in;  keep_ff <= keep_in;
      n_ff <= n_in;  fi_ff <= fi_in;  fj_ff <= fj_in;  k_ff <= k_in;
      found_ff <= found_in;  hit_ff <= hit_in;
      fit_ff <= fit_in;  cdx_ff <= cdx_in;  cdy_ff <= cdy_in;  bdx_ff <= bdx_in;
      bdy_ff <= bdy_in;  sqx_ff <= sqx_in;  sqy_ff <= sqy_in;  best_ff <= best_in;
      fail_ff <= fail_in;  resx_ff <= resx_in;  resy_ff <= resy_in;  ovf_ff <= ovf_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = fail_ff;
   assign rsp_place_x       = resx_ff;
   assign rsp_place_y       = resy_ff;
   assign rsp_list_overflow = ovf_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/free_rectangle_packer.sv
// Top level of the free rectangle packer.
//
//   channel   direction  transfer                        payload
//   request   in         start && !busy                  req_cmd, req_rect_x/y/w/h
//   response  out        rsp_valid, one cycle            rsp_status, rsp_place_x/y,
//                                                        rsp_list_overflow
//   csr       in         csr_valid && csr_ready          csr_index, csr_wdata
//
// One transaction at a time. A clear resets the free list to one entry covering the
// region and then responds. A search reads the free entries one by one through the
// single read port. Occupy and forbid then cut each entry that the target box overlaps
// into up to four pieces, filter the pieces and copy the survivors back into the list.
// Synchronous reset empties the list; the response side cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module free_rectangle_packer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic signed [11:0] req_rect_x,
   input  wire logic signed [11:0] req_rect_y,
   input  wire logic [10:0]        req_rect_w,
   input  wire logic [10:0]        req_rect_h,
   output logic                    rsp_valid,
   output logic                    rsp_status,
   output logic signed [11:0]      rsp_place_x,
   output logic signed [11:0]      rsp_place_y,
   output logic                    rsp_list_overflow,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [10:0]        csr_wdata
);
   import fpk_pkg::*;

   cfg_type cfg;
   ctl_type ctl;
   sts_type sts;

   fpk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fpk_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   fpk_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .cfg               (cfg),
      .req_cmd           (req_cmd),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_place_x       (rsp_place_x),
      .rsp_place_y       (rsp_place_y),
      .rsp_list_overflow (rsp_list_overflow)
   );

endmodule
`default_nettype wire
